FILE: hw/rtl/pbpr_pkg.sv
// shared types, constants and codes of the page buffer pool replacer
package pbpr_pkg;

	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 24;
	localparam int PIN_BITS_DEF  = 8;

	localparam int CMD_W    = 3;
	localparam int PAGE_W   = 24;
	localparam int FIDX_W   = 4;
	localparam int PINS_W   = 8;
	localparam int CNT_W    = 16;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_POLICY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_PIN   = 3'd0,
		CMD_UNPIN = 3'd1,
		CMD_DIRTY = 3'd2,
		CMD_FORCE = 3'd3,
		CMD_FLUSH = 3'd4,
		CMD_QUERY = 3'd5
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_VICT  = 2'd1,
		ST_NOT_RES  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_DECIDE,
		S_AGE,
		S_FLUSH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [PAGE_W-1:0] page_num;
		logic [FIDX_W-1:0] frame_index;
	} in_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [FIDX_W-1:0] frame;
		logic              hit;
		logic              need_read;
		logic              need_write;
		logic [PAGE_W-1:0] write_page;
		logic              frame_valid_out;
		logic [PAGE_W-1:0] frame_page_out;
		logic              frame_dirty_out;
		logic [PINS_W-1:0] frame_pins_out;
		logic [31:0]       io_totals;
		logic              last;
	} out_word_t;

	// controller to datapath
	typedef struct packed {
		logic load;      // latch command, clear scan results
		logic scan;      // examine frame at scan pointer
		logic decide;    // act on the scan result
		logic age;       // make-youngest update over all frames
		logic flush;     // flush step at scan pointer
		logic finish;    // emit the closing result
	} ctl_t;

	// datapath to controller
	typedef struct packed {
		logic scan_end;    // pointer at last managed frame
		logic need_age;    // decision requires an aging step
	} sts_t;

endpackage

FILE: hw/rtl/page_buffer_pool_replacer_unit.sv
// top level of the page buffer pool replacer: controller and datapath
// pin/unpin/dirty/force scan the n managed frames, one frame per scan cycle, then
//   decide and give their word; a pin that loads a frame or an lru hit that
//   reorders ages adds an aging step before the next command is taken
// flush gives one word per dirty managed frame, or a closing word if none; query gives one word
// throughput: one command at a time, busy high until its last word is out
// reset: async active low clears pool state, counters and config (fifo, 16 frames)
// the receiver cannot stall: each result word shows for one cycle under result_valid
module page_buffer_pool_replacer_unit
	import pbpr_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int PIN_BITS  = PIN_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  cmd_word,
	input  logic      cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic      result_valid,
	output out_word_t result_word
);

	ctl_t ctl;
	sts_t sts;

	pbpr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.start_cmd (cmd_word.cmd),
		.sts       (sts),
		.ctl       (ctl),
		.busy      (busy)
	);

	// flush words carry last from the datapath's look-ahead over dirty frames
	pbpr_datapath #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.PIN_BITS  (PIN_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_in       (cmd_word),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.ctl          (ctl),
		.sts          (sts),
		.result_valid (result_valid),
		.result_word  (result_word)
	);

endmodule

FILE: hw/rtl/pbpr_ctrl.sv
// command sequencer of the page buffer pool replacer
module pbpr_ctrl
	import pbpr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [CMD_W-1:0] start_cmd,
	input  sts_t sts,
	output ctl_t ctl,
	output logic busy
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (start_cmd == CMD_FLUSH) state_d = S_FLUSH;
					else if (start_cmd == CMD_QUERY) state_d = S_DONE;
					else if (start_cmd inside {CMD_PIN, CMD_UNPIN, CMD_DIRTY, CMD_FORCE})
						state_d = S_SCAN;
					else state_d = S_IDLE;
				end
			end
			S_SCAN: begin
				if (sts.scan_end) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				state_d = sts.need_age ? S_AGE : S_IDLE;
			end
			S_AGE: state_d = S_IDLE;
			S_FLUSH: begin
				if (sts.scan_end) state_d = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctl = '0;
		busy = (state_q != S_IDLE);
		case (state_q)
			S_IDLE:   ctl.load = start;
			S_SCAN:   ctl.scan = 1'b1;
			S_DECIDE: ctl.decide = 1'b1;
			S_AGE:    ctl.age = 1'b1;
			S_FLUSH:  ctl.flush = 1'b1;
			S_DONE:   ctl.finish = 1'b1;
			default:  ctl = '0;
		endcase
	end

`ifndef SYNTHESIS
	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.load, ctl.scan, ctl.decide, ctl.age, ctl.flush, ctl.finish}))
		else $error("more than one datapath command");
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |-> !busy)
		else $error("command loaded while busy");
	a_decide_after_scan: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.decide |-> $past(ctl.scan))
		else $error("decision without scan");
`endif

endmodule

FILE: hw/rtl/pbpr_datapath.sv
// frame table, scan unit and result register of the page buffer pool replacer
module pbpr_datapath
	import pbpr_pkg::*;
#(
	parameter int FRAMES    = FRAMES_DEF,
	parameter int PAGE_BITS = PAGE_BITS_DEF,
	parameter int PIN_BITS  = PIN_BITS_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  in_word_t  cmd_in,
	input  logic      cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ctl_t      ctl,
	output sts_t      sts,
	output logic      result_valid,
	output out_word_t result_word
);

	localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int AW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int NW = $clog2(FRAMES + 1);
	localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
	localparam logic [AW-1:0] AGE_MAX = AW'(FRAMES - 1);

	logic [PAGE_BITS-1:0] tag_q   [FRAMES];
	logic [FRAMES-1:0]    used_q;
	logic [FRAMES-1:0]    dirty_q;
	logic [PIN_BITS-1:0]  pins_q  [FRAMES];
	logic [AW-1:0]        age_q   [FRAMES];
	logic [CNT_W-1:0]     rd_cnt_q, wr_cnt_q;
	logic                 policy_q;
	logic [4:0]           fiu_q;

	logic [CMD_W-1:0]     cmd_q;
	logic [PAGE_BITS-1:0] page_q;
	logic [FIDX_W-1:0]    qidx_q;
	logic [FW-1:0]        ptr_q;
	logic                 hit_q, free_q, vict_q;
	logic [FW-1:0]        hit_idx_q, free_idx_q, vict_idx_q;
	logic [AW-1:0]        best_q;
	logic [AW:0]          old_q;   // age bound for make-youngest, FRAMES when fresh
	logic [FW-1:0]        tgt_q;
	logic                 any_q;
	logic [NW-1:0]        n_mng;

	assign n_mng = (fiu_q == 5'd0) ? NW'(1) :
		((32'(fiu_q) > FRAMES) ? NW'(FRAMES) : NW'(fiu_q));

	logic [NW-1:0] ptr_ext;
	assign ptr_ext = NW'(ptr_q);
	assign sts.scan_end = (ptr_ext == n_mng - NW'(1));

	// decision: pin miss with a free or victim frame, or LRU hit, needs aging
	assign sts.need_age = (cmd_q == CMD_PIN) &&
		((hit_q && policy_q) || (!hit_q && (free_q || vict_q)));

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
	endfunction

	// flush: a dirty frame's word carries last when no dirty managed frame lies above
	logic [FRAMES-1:0] above_dirty;
	always_comb begin
		for (int g = 0; g < FRAMES; g++)
			above_dirty[g] = 1'b0;
		for (int g = FRAMES - 2; g >= 0; g--)
			above_dirty[g] = above_dirty[g+1] ||
				(used_q[g+1] && dirty_q[g+1] && (g + 1) < 32'(n_mng));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		out_word_t     w;
		logic          v;
		logic [FW-1:0] s;
		logic          wb;
		if (!arst_n) begin
			used_q <= '0;
			dirty_q <= '0;
			for (int i = 0; i < FRAMES; i++) begin
				pins_q[i] <= '0;
				age_q[i] <= '0;
			end
			rd_cnt_q <= '0;
			wr_cnt_q <= '0;
			policy_q <= 1'b0;
			fiu_q <= 5'd16;
			result_valid <= 1'b0;
			result_word <= '0;
			ptr_q <= '0;
			any_q <= 1'b0;
		end else begin
			w = result_word;
			v = 1'b0;
			if (cfg_we) begin
				if (cfg_idx == REG_POLICY) policy_q <= cfg_data[0];
				else if (cfg_idx == REG_FRAMES) fiu_q <= cfg_data;
			end
			if (ctl.load) begin
				ptr_q <= '0;
				any_q <= 1'b0;
				hit_q <= 1'b0;
				free_q <= 1'b0;
				vict_q <= 1'b0;
				best_q <= '0;
			end
			if (ctl.scan) begin
				if (used_q[ptr_q] && tag_q[ptr_q] == page_q && !hit_q) begin
					hit_q <= 1'b1;
					hit_idx_q <= ptr_q;
				end
				if (!used_q[ptr_q] && !free_q) begin
					free_q <= 1'b1;
					free_idx_q <= ptr_q;
				end
				if (pins_q[ptr_q] == '0 && (!vict_q || age_q[ptr_q] > best_q)) begin
					vict_q <= 1'b1;
					vict_idx_q <= ptr_q;
					best_q <= age_q[ptr_q];
				end
				if (!sts.scan_end) ptr_q <= ptr_q + FW'(1);
			end
			if (ctl.decide) begin
				ptr_q <= '0;
				v = 1'b1;
				w = '0;
				w.last = 1'b1;
				if (cmd_q == CMD_PIN) begin
					if (hit_q) begin
						if (pins_q[hit_idx_q] != PIN_MAX)
							pins_q[hit_idx_q] <= pins_q[hit_idx_q] + PIN_BITS'(1);
						w.frame = FIDX_W'(hit_idx_q);
						w.hit = 1'b1;
						w.io_totals = {rd_cnt_q, wr_cnt_q};
						tgt_q <= hit_idx_q;
						old_q <= {1'b0, age_q[hit_idx_q]};
					end else if (free_q || vict_q) begin
						s = free_q ? free_idx_q : vict_idx_q;
						wb = !free_q && dirty_q[vict_idx_q];
						tgt_q <= s;
						old_q <= free_q ? (AW+1)'(FRAMES) : {1'b0, age_q[vict_idx_q]};
						used_q[s] <= 1'b1;
						tag_q[s] <= page_q;
						dirty_q[s] <= 1'b0;
						pins_q[s] <= PIN_BITS'(1);
						rd_cnt_q <= sat_inc(rd_cnt_q);
						if (wb) wr_cnt_q <= sat_inc(wr_cnt_q);
						w.frame = FIDX_W'(s);
						w.need_read = 1'b1;
						w.need_write = wb;
						w.write_page = wb ? PAGE_W'(tag_q[vict_idx_q]) : '0;
						w.io_totals = {sat_inc(rd_cnt_q),
							wb ? sat_inc(wr_cnt_q) : wr_cnt_q};
					end else begin
						w.status = ST_NO_VICT;
						w.io_totals = {rd_cnt_q, wr_cnt_q};
					end
				end else if (!hit_q) begin
					w.status = ST_NOT_RES;
					w.io_totals = {rd_cnt_q, wr_cnt_q};
				end else begin
					w.frame = FIDX_W'(hit_idx_q);
					w.io_totals = {rd_cnt_q, wr_cnt_q};
					if (cmd_q == CMD_UNPIN) begin
						if (pins_q[hit_idx_q] != '0)
							pins_q[hit_idx_q] <= pins_q[hit_idx_q] - PIN_BITS'(1);
					end else if (cmd_q == CMD_DIRTY) begin
						dirty_q[hit_idx_q] <= 1'b1;
					end else begin
						dirty_q[hit_idx_q] <= 1'b0;
						wr_cnt_q <= sat_inc(wr_cnt_q);
						w.need_write = 1'b1;
						w.write_page = PAGE_W'(tag_q[hit_idx_q]);
						w.io_totals = {rd_cnt_q, sat_inc(wr_cnt_q)};
					end
				end
			end
			// make-youngest over every frame, managed or not, in one step
			if (ctl.age) begin
				for (int g = 0; g < FRAMES; g++) begin
					if (FW'(g) == tgt_q) age_q[g] <= '0;
					else if (used_q[g] && {1'b0, age_q[g]} < old_q && age_q[g] < AGE_MAX)
						age_q[g] <= age_q[g] + AW'(1);
				end
			end
			if (ctl.flush) begin
				if (used_q[ptr_q] && dirty_q[ptr_q]) begin
					dirty_q[ptr_q] <= 1'b0;
					wr_cnt_q <= sat_inc(wr_cnt_q);
					any_q <= 1'b1;
					v = 1'b1;
					w = '0;
					w.frame = FIDX_W'(ptr_q);
					w.need_write = 1'b1;
					w.write_page = PAGE_W'(tag_q[ptr_q]);
					w.io_totals = {rd_cnt_q, sat_inc(wr_cnt_q)};
					w.last = !above_dirty[ptr_q];
				end
				if (!sts.scan_end) ptr_q <= ptr_q + FW'(1);
			end
			if (ctl.finish) begin
				if (cmd_q == CMD_QUERY) begin
					v = 1'b1;
					w = '0;
					w.frame = qidx_q;
					w.io_totals = {rd_cnt_q, wr_cnt_q};
					w.last = 1'b1;
					for (int g = 0; g < FRAMES; g++) begin
						if (32'(qidx_q) == g && used_q[g]) begin
							w.frame_valid_out = 1'b1;
							w.frame_page_out = PAGE_W'(tag_q[g]);
							w.frame_dirty_out = dirty_q[g];
							w.frame_pins_out = PINS_W'(pins_q[g]);
						end
					end
				end else if (!any_q) begin
					v = 1'b1;
					w = '0;
					w.io_totals = {rd_cnt_q, wr_cnt_q};
					w.last = 1'b1;
				end
			end
			result_valid <= v;
			result_word <= w;
		end
	end

	// command latch, payload only
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q <= cmd_in.cmd;
			page_q <= PAGE_BITS'(cmd_in.page_num);
			qidx_q <= cmd_in.frame_index;
		end
	end

`ifndef SYNTHESIS
	a_hit_is_used: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.decide && hit_q) |-> used_q[hit_idx_q])
		else $error("hit on unused frame");
	a_ptr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.scan || ctl.flush) |-> (ptr_ext < n_mng))
		else $error("scan pointer beyond managed frames");
	a_read_count_mono: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> (rd_cnt_q >= $past(rd_cnt_q)))
		else $error("read counter went down");
`endif

endmodule
